### design/cbt_pkg.sv
package cbt_pkg;

	// default tree depth: 2^10 leaves
	localparam int TREE_DEPTH_DEF = 10;

	// fixed field widths
	localparam int CMD_W = 2;
	localparam int OPI_W = 10;
	localparam int ANS_W = 11;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_REBUILD = 2'd1,
		CMD_FIND    = 2'd2,
		CMD_PREFIX  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RB_RD,
		ST_RB_WR,
		ST_FIN
	} state_t;

endpackage

### design/cbt_if.sv
// input item channel
interface cbt_in_if import cbt_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [OPI_W-1:0] operand_index;
	logic             bit_value;

	modport source (output valid, cmd, operand_index, bit_value, input ready);
	modport sink   (input valid, cmd, operand_index, bit_value, output ready);
endinterface

// result item channel
interface cbt_out_if import cbt_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ANS_W-1:0] answer;
	logic             not_found;
	logic [ANS_W-1:0] total_ones;

	modport source (output valid, answer, not_found, total_ones, input ready);
	modport sink   (input valid, answer, not_found, total_ones, output ready);
endinterface

### design/cbt_node_ram.sv
// node count store: one write port, two registered read ports
module cbt_node_ram #(
	parameter int AW = 11,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0_q,
	output logic [DW-1:0] rdata1_q
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0_q <= mem_q[raddr0];
		rdata1_q <= mem_q[raddr1];
	end

endmodule

### design/concurrent_binary_tree_bitmap.sv
// Sum tree over a bitmap of 2^TREE_DEPTH leaf bits.
// in_ch carries one command item (cmd, operand_index, bit_value); out_ch
// returns one result item per command (answer, not_found, total_ones).
// Node counts sit in one memory indexed by heap node number, each entry
// TREE_DEPTH+1 bits wide; leaves are the top half of the heap.
// Steps from accept to result valid; the next item is taken once the block is idle again:
//   write leaf, or find with rank out of range: the result is loaded directly
//   find, prefix: one node read per level, then the result is loaded
//   rebuild: read two children then write parent, for each parent node
// The block takes one item at a time; in_ch.ready is high only while idle.
// The result register decouples the sides: a new item is accepted while a
// result waits; the block holds its next result until out_ch.ready frees it.
// After reset the block clears the node store, one entry per cycle, all
// 2^(TREE_DEPTH+1) entries (2048 at depth 10), before it accepts an item.
// total_ones is the root count as of the last rebuild.
module concurrent_binary_tree_bitmap import cbt_pkg::*; #(
	parameter int TREE_DEPTH = TREE_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cbt_in_if.sink   in_ch,
	cbt_out_if.source out_ch
);

	localparam int D     = TREE_DEPTH;
	localparam int AW    = D + 1;
	localparam int CW    = D + 1;
	localparam int RW    = (CW > OPI_W) ? CW : OPI_W;
	localparam int LVL_W = $clog2(D + 1);

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [AW-1:0]    h_q;
	logic [LVL_W-1:0] lvl_q;
	logic [RW-1:0]    rank_q;
	logic [CW-1:0]    sum_q;
	logic [D-1:0]     leaf_q;
	logic [D-1:0]     k_q;
	logic [AW-1:0]    clr_q;
	logic             nf_q;
	logic [CW-1:0]    root_q;
	logic             out_v_q;
	logic [ANS_W-1:0] ans_q;
	logic             out_nf_q;
	logic [ANS_W-1:0] tot_q;

	logic          we;
	logic [AW-1:0] waddr, raddr0, raddr1;
	logic [CW-1:0] wdata, rd0, rd1;
	logic          accept, go_right, last_lvl, fin_load;
	logic [AW-1:0] h_next;
	logic [CW-1:0] ans_c, child_sum;

	cbt_node_ram #(.AW(AW), .DW(CW)) u_ram (
		.clk      (clk),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr0   (raddr0),
		.raddr1   (raddr1),
		.rdata0_q (rd0),
		.rdata1_q (rd1)
	);

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign accept           = in_ch.valid && in_ch.ready;
	assign out_ch.valid     = out_v_q;
	assign out_ch.answer    = ans_q;
	assign out_ch.not_found = out_nf_q;
	assign out_ch.total_ones = tot_q;

	// walk step: decide direction from the left child count (find) or the leaf index bit (prefix)
	always_comb begin
		if (cmd_q == CMD_FIND) begin
			go_right = (RW'(rd0) <= rank_q);
		end else begin
			go_right = leaf_q[D-1];
		end
	end
	assign h_next    = {h_q[AW-2:0], go_right};
	assign last_lvl  = (lvl_q == LVL_W'(D - 1));
	assign child_sum = rd0 + rd1;
	assign fin_load  = (state_q == ST_FIN) && (!out_v_q || out_ch.ready);

	// answer by command
	always_comb begin
		case (cmd_q)
			CMD_FIND:   ans_c = nf_q ? '0 : CW'(h_q[D-1:0]);
			CMD_PREFIX: ans_c = sum_q;
			default:    ans_c = '0;
		endcase
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = clr_q;
		wdata   = '0;
		raddr0  = {k_q, 1'b0};
		raddr1  = {k_q, 1'b1};
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				raddr0 = AW'(2);
				if (accept) begin
					case (cmd_t'(in_ch.cmd))
						CMD_WRITE: begin
							we      = 1'b1;
							waddr   = {1'b1, D'(in_ch.operand_index)};
							wdata   = CW'(in_ch.bit_value);
							state_d = ST_FIN;
						end
						CMD_REBUILD: state_d = ST_RB_RD;
						CMD_FIND: begin
							state_d = (RW'(in_ch.operand_index) >= RW'(root_q)) ?
								ST_FIN : ST_WALK;
						end
						CMD_PREFIX: state_d = ST_WALK;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_WALK: begin
				raddr0 = {h_next[AW-2:0], 1'b0};
				if (last_lvl) begin
					state_d = ST_FIN;
				end
			end
			ST_RB_RD: state_d = ST_RB_WR;
			ST_RB_WR: begin
				we      = 1'b1;
				waddr   = AW'(k_q);
				wdata   = child_sum;
				state_d = (k_q == D'(1)) ? ST_FIN : ST_RB_RD;
			end
			ST_FIN: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			root_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_RB_WR && k_q == D'(1)) begin
				root_q <= child_sum;
			end
			if (fin_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(in_ch.cmd);
			h_q    <= AW'(1);
			lvl_q  <= '0;
			rank_q <= RW'(in_ch.operand_index);
			sum_q  <= '0;
			leaf_q <= D'(in_ch.operand_index);
			k_q    <= '1;
			nf_q   <= (RW'(in_ch.operand_index) >= RW'(root_q));
		end
		if (state_q == ST_WALK) begin
			h_q    <= h_next;
			lvl_q  <= lvl_q + LVL_W'(1);
			leaf_q <= leaf_q << 1;
			if (go_right) begin
				rank_q <= rank_q - RW'(rd0);
				sum_q  <= sum_q + rd0;
			end
		end
		if (state_q == ST_RB_WR) begin
			k_q <= k_q - D'(1);
		end
		if (fin_load) begin
			ans_q    <= ANS_W'(ans_c);
			out_nf_q <= (cmd_q == CMD_FIND) && nf_q;
			tot_q    <= ANS_W'(root_q);
		end
	end

endmodule

### design/cbt_checker.sv
// port-level checks for the tree block
module cbt_checker import cbt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [ANS_W-1:0] answer,
	input logic             not_found,
	input logic [ANS_W-1:0] total_ones
);

	// a stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(answer) && $stable(not_found) &&
			$stable(total_ones))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted back to back");

	// a failed find answers zero
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_found |-> answer == '0)
		else $error("not_found with nonzero answer");

endmodule

bind concurrent_binary_tree_bitmap cbt_checker u_cbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.answer     (out_ch.answer),
	.not_found  (out_ch.not_found),
	.total_ones (out_ch.total_ones)
);
